>>> hw/rtl/tbs_pkg.sv
`timescale 1ns / 1ps

package tbs_pkg;

    // Width of every running counter; results are 32 bits wide.
    localparam int CNT_W   = 32;
    localparam int FIELD_W = 32;

    // Depth of the queue between the classifier and the counters.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Item kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_EOT  = 1'b1;

    // Byte codes the classifier looks for.
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [FIELD_W-1:0] t_field;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        logic eot;
        logic is_nl;
        logic is_brace;
        logic is_bracket;
        logic is_quote;
        logic is_digit;
        logic is_symbol;
        logic is_control;
    } t_item;

    // Queue status seen by the back end.
    typedef struct packed {
        logic  empty;
        t_item item;
    } t_q_head;

    // Saturating increment.
    function automatic t_cnt sat_inc(input t_cnt v);
        return (v == {CNT_W{1'b1}}) ? v : v + t_cnt'(1);
    endfunction

    // Fit a counter into a result field, clamping values that are too wide.
    function automatic t_field to_field(input t_cnt v);
        logic [CNT_W+FIELD_W-1:0] wide;
        wide = {{FIELD_W{1'b0}}, v};
        if (wide[CNT_W+FIELD_W-1:FIELD_W] != '0) begin
            return {FIELD_W{1'b1}};
        end
        return wide[FIELD_W-1:0];
    endfunction

endpackage

>>> hw/rtl/tbs_front.sv
`timescale 1ns / 1ps

module tbs_front (
    input  logic          i_kind,
    input  logic [7:0]    i_data_byte,
    output tbs_pkg::t_item o_item
);

    logic is_alnum;
    logic is_space;

    // Byte class decode.
    always_comb begin
        is_alnum = (i_data_byte inside {[tbs_pkg::CH_ZERO:tbs_pkg::CH_NINE],
                                        [tbs_pkg::CH_UPPER_A:tbs_pkg::CH_UPPER_Z],
                                        [tbs_pkg::CH_LOWER_A:tbs_pkg::CH_LOWER_Z]});
        is_space = (i_data_byte inside {tbs_pkg::CH_SPACE,
                                        [tbs_pkg::CH_TAB:tbs_pkg::CH_CR]});

        o_item.eot        = (i_kind == tbs_pkg::KIND_EOT);
        o_item.is_nl      = (i_data_byte == tbs_pkg::CH_LF);
        o_item.is_brace   = (i_data_byte inside {tbs_pkg::CH_LBRACE, tbs_pkg::CH_RBRACE});
        o_item.is_bracket = (i_data_byte inside {tbs_pkg::CH_LBRACK, tbs_pkg::CH_RBRACK});
        o_item.is_quote   = (i_data_byte == tbs_pkg::CH_QUOTE);
        o_item.is_digit   = (i_data_byte inside {[tbs_pkg::CH_ZERO:tbs_pkg::CH_NINE]});
        o_item.is_symbol  = !is_alnum && !is_space;
        o_item.is_control = (i_data_byte < tbs_pkg::CH_SPACE) &&
                            !(i_data_byte inside {tbs_pkg::CH_LF, tbs_pkg::CH_CR,
                                                  tbs_pkg::CH_TAB});
    end

endmodule

>>> hw/rtl/tbs_queue.sv
`timescale 1ns / 1ps

module tbs_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  tbs_pkg::t_item    i_item,
    output logic              o_full,
    input  logic              i_rd,
    output tbs_pkg::t_q_head  o_head
);

    tbs_pkg::t_item                 r_mem [tbs_pkg::QDEPTH];
    logic [tbs_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [tbs_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [tbs_pkg::QCNT_W-1:0]     r_count;
    logic [tbs_pkg::QPTR_W-1:0]     n_wr_ptr;
    logic [tbs_pkg::QPTR_W-1:0]     n_rd_ptr;
    logic [tbs_pkg::QCNT_W-1:0]     n_count;
    logic                           wr_en;
    logic                           rd_en;

    assign o_full       = (r_count == tbs_pkg::QCNT_W'(tbs_pkg::QDEPTH));
    assign o_head.empty = (r_count == '0);
    assign o_head.item  = r_mem[r_rd_ptr];

    assign wr_en = i_wr && !o_full;
    assign rd_en = i_rd && !o_head.empty;

    // Pointer and fill bookkeeping; pointers wrap at the queue depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == tbs_pkg::QPTR_W'(tbs_pkg::QDEPTH - 1)) ?
                       '0 : r_wr_ptr + tbs_pkg::QPTR_W'(1);
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == tbs_pkg::QPTR_W'(tbs_pkg::QDEPTH - 1)) ?
                       '0 : r_rd_ptr + tbs_pkg::QPTR_W'(1);
        end
        n_count = r_count + tbs_pkg::QCNT_W'(wr_en) - tbs_pkg::QCNT_W'(rd_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage for queued items.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tbs_pkg::QCNT_W'(tbs_pkg::QDEPTH))
        else $error("queue fill count beyond depth");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && !rd_en) |=> (r_count == $past(r_count) + tbs_pkg::QCNT_W'(1)))
        else $error("queue fill count did not follow a write");

endmodule

>>> hw/rtl/tbs_back.sv
`timescale 1ns / 1ps

module tbs_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tbs_pkg::t_q_head     i_head,
    output logic                 o_q_rd,
    input  logic                 i_pop,
    output logic                 o_empty,
    output tbs_pkg::t_field      o_byte_count,
    output tbs_pkg::t_field      o_line_count,
    output tbs_pkg::t_field      o_brace_count,
    output tbs_pkg::t_field      o_bracket_count,
    output tbs_pkg::t_field      o_quote_count,
    output tbs_pkg::t_field      o_digit_count,
    output tbs_pkg::t_field      o_symbol_count,
    output tbs_pkg::t_field      o_control_count,
    output tbs_pkg::t_field      o_longest_line
);

    tbs_pkg::t_cnt   r_bytes, r_newlines, r_braces, r_brackets, r_quotes;
    tbs_pkg::t_cnt   r_digits, r_symbols, r_controls, r_run_len, r_longest;
    tbs_pkg::t_field r_byte_count, r_line_count, r_brace_count, r_bracket_count;
    tbs_pkg::t_field r_quote_count, r_digit_count, r_symbol_count, r_control_count;
    tbs_pkg::t_field r_longest_line;
    tbs_pkg::t_cnt   longest_now;
    tbs_pkg::t_cnt   lines_now;
    logic            r_out_valid;
    logic            slot_free;
    logic            take_byte;
    logic            take_eot;

    assign o_empty   = !r_out_valid;
    assign slot_free = !r_out_valid || i_pop;
    assign o_q_rd    = !i_head.empty && (!i_head.item.eot || slot_free);
    assign take_byte = o_q_rd && !i_head.item.eot;
    assign take_eot  = o_q_rd && i_head.item.eot;

    // Final line and longest-line figures for an end-of-text transfer.
    assign longest_now = (r_run_len > r_longest) ? r_run_len : r_longest;
    assign lines_now   = (r_bytes == '0) ? '0 : tbs_pkg::sat_inc(r_newlines);

    // Result register drives the result ports.
    assign o_byte_count    = r_byte_count;
    assign o_line_count    = r_line_count;
    assign o_brace_count   = r_brace_count;
    assign o_bracket_count = r_bracket_count;
    assign o_quote_count   = r_quote_count;
    assign o_digit_count   = r_digit_count;
    assign o_symbol_count  = r_symbol_count;
    assign o_control_count = r_control_count;
    assign o_longest_line  = r_longest_line;

    // Running counters: a byte updates them, end of text clears them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || take_eot) begin
            r_bytes    <= '0;
            r_newlines <= '0;
            r_braces   <= '0;
            r_brackets <= '0;
            r_quotes   <= '0;
            r_digits   <= '0;
            r_symbols  <= '0;
            r_controls <= '0;
            r_run_len  <= '0;
            r_longest  <= '0;
        end else if (take_byte) begin
            r_bytes <= tbs_pkg::sat_inc(r_bytes);
            if (i_head.item.is_nl) begin
                r_newlines <= tbs_pkg::sat_inc(r_newlines);
                r_longest  <= longest_now;
                r_run_len  <= '0;
            end else begin
                r_run_len <= tbs_pkg::sat_inc(r_run_len);
            end
            if (i_head.item.is_brace) begin
                r_braces <= tbs_pkg::sat_inc(r_braces);
            end
            if (i_head.item.is_bracket) begin
                r_brackets <= tbs_pkg::sat_inc(r_brackets);
            end
            if (i_head.item.is_quote) begin
                r_quotes <= tbs_pkg::sat_inc(r_quotes);
            end
            if (i_head.item.is_digit) begin
                r_digits <= tbs_pkg::sat_inc(r_digits);
            end
            if (i_head.item.is_symbol) begin
                r_symbols <= tbs_pkg::sat_inc(r_symbols);
            end
            if (i_head.item.is_control) begin
                r_controls <= tbs_pkg::sat_inc(r_controls);
            end
        end
    end

    // Result slot valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take_eot) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload, loaded when end of text reaches the counters.
    always_ff @(posedge i_clk) begin
        if (take_eot) begin
            r_byte_count    <= tbs_pkg::to_field(r_bytes);
            r_line_count    <= tbs_pkg::to_field(lines_now);
            r_brace_count   <= tbs_pkg::to_field(r_braces);
            r_bracket_count <= tbs_pkg::to_field(r_brackets);
            r_quote_count   <= tbs_pkg::to_field(r_quotes);
            r_digit_count   <= tbs_pkg::to_field(r_digits);
            r_symbol_count  <= tbs_pkg::to_field(r_symbols);
            r_control_count <= tbs_pkg::to_field(r_controls);
            r_longest_line  <= tbs_pkg::to_field(longest_now);
        end
    end

    a_eot_fills_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_eot |=> r_out_valid)
        else $error("end of text did not produce a result");

    a_eot_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_eot |=> (r_bytes == '0 && r_run_len == '0 && r_longest == '0))
        else $error("counters not cleared after end of text");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_eot |-> (!r_out_valid || i_pop))
        else $error("result slot overwritten before transfer");

    a_line_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_longest <= r_bytes)
        else $error("longest line exceeds byte count");

endmodule

>>> hw/rtl/text_byte_statistics.sv
`timescale 1ns / 1ps
// Path: the queue holds each item until the counters take it from the queue head;
// an end-of-text item loads the result register, which drives the outputs.
// Throughput: one item per cycle; the counter stage takes one item per cycle
// and holds an end-of-text item only while the result register is occupied.
// Reset (synchronous, active low) clears the queue, all counters and the result slot.
module text_byte_statistics (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 i_kind,
    input  logic [7:0]           i_data_byte,
    input  logic                 pop,
    output logic                 empty,
    output tbs_pkg::t_field      o_byte_count,
    output tbs_pkg::t_field      o_line_count,
    output tbs_pkg::t_field      o_brace_count,
    output tbs_pkg::t_field      o_bracket_count,
    output tbs_pkg::t_field      o_quote_count,
    output tbs_pkg::t_field      o_digit_count,
    output tbs_pkg::t_field      o_symbol_count,
    output tbs_pkg::t_field      o_control_count,
    output tbs_pkg::t_field      o_longest_line
);

    tbs_pkg::t_item   front_item;
    tbs_pkg::t_q_head q_head;
    logic             q_rd;

    // Classifier on the input side.
    tbs_front u_front (
        .i_kind      (i_kind),
        .i_data_byte (i_data_byte),
        .o_item      (front_item)
    );

    // Decoupling queue.
    tbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_rd    (q_rd),
        .o_head  (q_head)
    );

    // Counters and result register.
    tbs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (q_head),
        .o_q_rd          (q_rd),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_byte_count    (o_byte_count),
        .o_line_count    (o_line_count),
        .o_brace_count   (o_brace_count),
        .o_bracket_count (o_bracket_count),
        .o_quote_count   (o_quote_count),
        .o_digit_count   (o_digit_count),
        .o_symbol_count  (o_symbol_count),
        .o_control_count (o_control_count),
        .o_longest_line  (o_longest_line)
    );

endmodule

>>> bench/tb_text_byte_statistics.sv
`timescale 1ns / 1ps

module tb_text_byte_statistics;

    localparam int ITEM_TARGET = 1350;
    localparam int TAIL_ITEMS  = 150;
    localparam int REPORT_MAX  = 10;
    localparam int N_STATS     = 9;
    localparam int ROW_MAX     = 32;
    localparam int EXP_DEPTH   = 64;

    // Position of each statistic inside one packed result record.
    typedef enum int {
        ST_BYTES,
        ST_LINES,
        ST_BRACES,
        ST_BRACKETS,
        ST_QUOTES,
        ST_DIGITS,
        ST_SYMBOLS,
        ST_CONTROLS,
        ST_LONGEST
    } t_stat_idx;

    typedef logic [N_STATS-1:0][tbs_pkg::FIELD_W-1:0] t_text_stats;

    // One row of the directed stimulus; typed rows carry their own expected statistics.
    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic        typed;
        t_text_stats want;
    } t_stim_row;

    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            push        = 1'b0;
    logic            i_kind      = 1'b0;
    logic [7:0]      i_data_byte = 8'h00;
    logic            pop         = 1'b0;
    logic            full;
    logic            empty;
    tbs_pkg::t_field o_byte_count;
    tbs_pkg::t_field o_line_count;
    tbs_pkg::t_field o_brace_count;
    tbs_pkg::t_field o_bracket_count;
    tbs_pkg::t_field o_quote_count;
    tbs_pkg::t_field o_digit_count;
    tbs_pkg::t_field o_symbol_count;
    tbs_pkg::t_field o_control_count;
    tbs_pkg::t_field o_longest_line;

    // Running text statistics as the block should hold them.
    tbs_pkg::t_cnt n_bytes     = '0;
    tbs_pkg::t_cnt n_newlines  = '0;
    tbs_pkg::t_cnt n_braces    = '0;
    tbs_pkg::t_cnt n_brackets  = '0;
    tbs_pkg::t_cnt n_quotes    = '0;
    tbs_pkg::t_cnt n_digits    = '0;
    tbs_pkg::t_cnt n_symbols   = '0;
    tbs_pkg::t_cnt n_controls  = '0;
    tbs_pkg::t_cnt line_len    = '0;
    tbs_pkg::t_cnt longest_len = '0;

    t_text_stats expected_stats [EXP_DEPTH];
    int          exp_wr = 0;
    int          exp_rd = 0;
    t_stim_row   directed_rows [ROW_MAX];
    int          row_count = 0;
    string       field_names [N_STATS] = '{"byte_count", "line_count", "brace_count",
        "bracket_count", "quote_count", "digit_count", "symbol_count", "control_count",
        "longest_line"};

    int   items_sent = 0;
    int   failures   = 0;
    logic no_gaps    = 1'b0;
    int   pop_hold   = 0;

    text_byte_statistics dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_kind          (i_kind),
        .i_data_byte     (i_data_byte),
        .pop             (pop),
        .empty           (empty),
        .o_byte_count    (o_byte_count),
        .o_line_count    (o_line_count),
        .o_brace_count   (o_brace_count),
        .o_bracket_count (o_bracket_count),
        .o_quote_count   (o_quote_count),
        .o_digit_count   (o_digit_count),
        .o_symbol_count  (o_symbol_count),
        .o_control_count (o_control_count),
        .o_longest_line  (o_longest_line)
    );

    always #5 i_clk = ~i_clk;

    // Counters stop at their maximum instead of wrapping.
    function automatic tbs_pkg::t_cnt sat_bump(input tbs_pkg::t_cnt v);
        return (&v) ? v : v + tbs_pkg::t_cnt'(1);
    endfunction

    // A counter too large for a result field reads as all ones.
    function automatic tbs_pkg::t_field fit_field(input tbs_pkg::t_cnt v);
        logic [tbs_pkg::CNT_W+tbs_pkg::FIELD_W-1:0] wide;
        wide = {{tbs_pkg::FIELD_W{1'b0}}, v};
        if (wide[tbs_pkg::CNT_W+tbs_pkg::FIELD_W-1:tbs_pkg::FIELD_W] != '0) begin
            return '1;
        end
        return wide[tbs_pkg::FIELD_W-1:0];
    endfunction

    // Update the running statistics with one item; returns 1 when the item ends a text.
    function automatic bit tally_item(input logic kind, input logic [7:0] b,
                                      output t_text_stats res);
        bit alnum;
        bit blank;
        res = '0;
        if (kind == tbs_pkg::KIND_BYTE) begin
            alnum = (b >= tbs_pkg::CH_ZERO && b <= tbs_pkg::CH_NINE)
                    || (b >= tbs_pkg::CH_UPPER_A && b <= tbs_pkg::CH_UPPER_Z)
                    || (b >= tbs_pkg::CH_LOWER_A && b <= tbs_pkg::CH_LOWER_Z);
            blank = (b == tbs_pkg::CH_SPACE) || (b >= tbs_pkg::CH_TAB && b <= tbs_pkg::CH_CR);
            n_bytes = sat_bump(n_bytes);
            if (b == tbs_pkg::CH_LF) begin
                n_newlines = sat_bump(n_newlines);
                if (line_len > longest_len) begin
                    longest_len = line_len;
                end
                line_len = '0;
            end else begin
                line_len = sat_bump(line_len);
            end
            if (b == tbs_pkg::CH_LBRACE || b == tbs_pkg::CH_RBRACE) begin
                n_braces = sat_bump(n_braces);
            end
            if (b == tbs_pkg::CH_LBRACK || b == tbs_pkg::CH_RBRACK) begin
                n_brackets = sat_bump(n_brackets);
            end
            if (b == tbs_pkg::CH_QUOTE) n_quotes = sat_bump(n_quotes);
            if (b >= tbs_pkg::CH_ZERO && b <= tbs_pkg::CH_NINE) n_digits = sat_bump(n_digits);
            if (!alnum && !blank) n_symbols = sat_bump(n_symbols);
            if (b < tbs_pkg::CH_SPACE && b != tbs_pkg::CH_LF && b != tbs_pkg::CH_CR
                && b != tbs_pkg::CH_TAB) begin
                n_controls = sat_bump(n_controls);
            end
            return 1'b0;
        end

        // End of text: report everything, counting the unterminated last line.
        res[ST_BYTES]    = fit_field(n_bytes);
        res[ST_LINES]    = fit_field((n_bytes == '0) ? '0 : sat_bump(n_newlines));
        res[ST_BRACES]   = fit_field(n_braces);
        res[ST_BRACKETS] = fit_field(n_brackets);
        res[ST_QUOTES]   = fit_field(n_quotes);
        res[ST_DIGITS]   = fit_field(n_digits);
        res[ST_SYMBOLS]  = fit_field(n_symbols);
        res[ST_CONTROLS] = fit_field(n_controls);
        res[ST_LONGEST]  = fit_field((line_len > longest_len) ? line_len : longest_len);
        n_bytes     = '0;
        n_newlines  = '0;
        n_braces    = '0;
        n_brackets  = '0;
        n_quotes    = '0;
        n_digits    = '0;
        n_symbols   = '0;
        n_controls  = '0;
        line_len    = '0;
        longest_len = '0;
        return 1'b1;
    endfunction

    function automatic t_text_stats make_stats(input int unsigned nb, nl, nbr, nbk, nq, nd,
                                               ns, nc, ll);
        t_text_stats s;
        s[ST_BYTES]    = nb;
        s[ST_LINES]    = nl;
        s[ST_BRACES]   = nbr;
        s[ST_BRACKETS] = nbk;
        s[ST_QUOTES]   = nq;
        s[ST_DIGITS]   = nd;
        s[ST_SYMBOLS]  = ns;
        s[ST_CONTROLS] = nc;
        s[ST_LONGEST]  = ll;
        return s;
    endfunction

    function automatic void add_row(input logic kind, input logic [7:0] data,
                                    input logic typed, input t_text_stats want);
        directed_rows[row_count] = '{kind, data, typed, want};
        row_count++;
    endfunction

    // Text-like bytes with every class well represented, newlines frequent.
    function automatic logic [7:0] pick_text_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12) return tbs_pkg::CH_LF;
        if (r < 20) begin
            case ($urandom_range(0, 4))
                0: return tbs_pkg::CH_LBRACE;
                1: return tbs_pkg::CH_RBRACE;
                2: return tbs_pkg::CH_LBRACK;
                3: return tbs_pkg::CH_RBRACK;
                default: return tbs_pkg::CH_QUOTE;
            endcase
        end
        if (r < 32) return tbs_pkg::CH_ZERO + 8'($urandom_range(0, 9));
        if (r < 46) return tbs_pkg::CH_UPPER_A + 8'($urandom_range(0, 25));
        if (r < 60) return tbs_pkg::CH_LOWER_A + 8'($urandom_range(0, 25));
        if (r < 68) begin
            case ($urandom_range(0, 4))
                0: return tbs_pkg::CH_SPACE;
                1: return tbs_pkg::CH_TAB;
                2: return tbs_pkg::CH_CR;
                3: return tbs_pkg::CH_VT;
                default: return tbs_pkg::CH_FF;
            endcase
        end
        if (r < 78) return 8'($urandom_range(0, 31));
        if (r < 88) return 8'($urandom_range(128, 255));
        return 8'($urandom_range(33, 126));
    endfunction

    // Drive one item until its transfer, with an occasional gap in front of it.
    task automatic send_item(input logic kind, input logic [7:0] b, input logic typed,
                             input t_text_stats want);
        t_text_stats res;
        if (!no_gaps && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_kind      <= kind;
        i_data_byte <= b;
        do @(posedge i_clk); while (full);
        items_sent++;
        if (tally_item(kind, b, res)) begin
            expected_stats[exp_wr % EXP_DEPTH] = typed ? want : res;
            exp_wr++;
        end
    endtask

    // Result side: pop stalls in random bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop      <= 1'b0;
            pop_hold <= 0;
        end else if (pop_hold != 0) begin
            pop      <= 1'b0;
            pop_hold <= pop_hold - 1;
        end else if (!no_gaps && $urandom_range(0, 5) == 0) begin
            pop      <= 1'b0;
            pop_hold <= $urandom_range(0, 13);
        end else begin
            pop <= 1'b1;
        end
    end

    // Compare each result transfer with the oldest expected statistics.
    always @(posedge i_clk) begin : check_result
        t_text_stats got;
        t_text_stats want;
        int          bad;
        if (i_rst_n && pop && !empty) begin
            got[ST_BYTES]    = o_byte_count;
            got[ST_LINES]    = o_line_count;
            got[ST_BRACES]   = o_brace_count;
            got[ST_BRACKETS] = o_bracket_count;
            got[ST_QUOTES]   = o_quote_count;
            got[ST_DIGITS]   = o_digit_count;
            got[ST_SYMBOLS]  = o_symbol_count;
            got[ST_CONTROLS] = o_control_count;
            got[ST_LONGEST]  = o_longest_line;
            if (exp_rd == exp_wr) begin
                if (failures < REPORT_MAX) begin
                    $display("unexpected result at %0t: byte_count=%0d", $realtime,
                             got[ST_BYTES]);
                end
                failures++;
            end else begin
                want = expected_stats[exp_rd % EXP_DEPTH];
                exp_rd++;
                bad  = 0;
                for (int f = 0; f < N_STATS; f++) begin
                    if (got[f] !== want[f]) begin
                        if (failures < REPORT_MAX) begin
                            $display("mismatch at %0t in %s: expected %0d, got %0d",
                                     $realtime, field_names[f], want[f], got[f]);
                        end
                        bad++;
                    end
                end
                if (bad != 0) failures++;
            end
        end
    end

    initial begin : stimulus
        t_text_stats none;
        int          len;
        int          sel;
        none = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty texts, the second with every data bit set on the end-of-text item.
        add_row(tbs_pkg::KIND_EOT, 8'h00, 1'b1, none);
        add_row(tbs_pkg::KIND_EOT, 8'hFF, 1'b1, none);
        // A letter, a NUL (symbol and control) and a high byte, no newline.
        add_row(tbs_pkg::KIND_BYTE, tbs_pkg::CH_UPPER_A, 1'b0, none);
        add_row(tbs_pkg::KIND_BYTE, 8'h00, 1'b0, none);
        add_row(tbs_pkg::KIND_BYTE, 8'hFF, 1'b0, none);
        add_row(tbs_pkg::KIND_EOT, 8'h00, 1'b1, make_stats(3, 1, 0, 0, 0, 0, 2, 1, 3));
        // Every punctuation class, digit extremes and all whitespace codes.
        add_row(tbs_pkg::KIND_BYTE, tbs_pkg::CH_LBRACE, 1'b0, none);
        add_row(tbs_pkg::KIND_BYTE, tbs_pkg::CH_RBRACE, 1'b0, none);
        add_row(tbs_pkg::KIND_BYTE, tbs_pkg::CH_LBRACK, 1'b0, none);
        add_row(tbs_pkg::KIND_BYTE, tbs_pkg::CH_RBRACK, 1'b0, none);
        add_row(tbs_pkg::KIND_BYTE, tbs_pkg::CH_QUOTE, 1'b0, none);
        add_row(tbs_pkg::KIND_BYTE, tbs_pkg::CH_ZERO, 1'b0, none);
        add_row(tbs_pkg::KIND_BYTE, tbs_pkg::CH_NINE, 1'b0, none);
        add_row(tbs_pkg::KIND_BYTE, tbs_pkg::CH_LF, 1'b0, none);
        add_row(tbs_pkg::KIND_BYTE, tbs_pkg::CH_CR, 1'b0, none);
        add_row(tbs_pkg::KIND_BYTE, tbs_pkg::CH_TAB, 1'b0, none);
        add_row(tbs_pkg::KIND_BYTE, tbs_pkg::CH_VT, 1'b0, none);
        add_row(tbs_pkg::KIND_BYTE, tbs_pkg::CH_FF, 1'b0, none);
        add_row(tbs_pkg::KIND_BYTE, tbs_pkg::CH_SPACE, 1'b0, none);
        add_row(tbs_pkg::KIND_BYTE, 8'h1F, 1'b0, none);
        add_row(tbs_pkg::KIND_BYTE, 8'h80, 1'b0, none);
        add_row(tbs_pkg::KIND_BYTE, tbs_pkg::CH_LF, 1'b0, none);
        add_row(tbs_pkg::KIND_EOT, 8'h5A, 1'b0, none);
        // A text that is a single newline: two lines, both empty.
        add_row(tbs_pkg::KIND_BYTE, tbs_pkg::CH_LF, 1'b0, none);
        add_row(tbs_pkg::KIND_EOT, 8'hA5, 1'b1, make_stats(1, 2, 0, 0, 0, 0, 0, 0, 0));

        for (int i = 0; i < row_count; i++) begin
            send_item(directed_rows[i].kind, directed_rows[i].data, directed_rows[i].typed,
                      directed_rows[i].want);
        end

        // Random texts: mostly short, a few long, some empty; the tail runs without gaps.
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= ITEM_TARGET - TAIL_ITEMS) begin
                no_gaps = 1'b1;
            end else begin
                no_gaps = ($urandom_range(0, 3) == 0);
            end
            sel = $urandom_range(0, 19);
            if (sel == 0) begin
                len = 0;
            end else if (sel <= 2) begin
                len = $urandom_range(31, 120);
            end else begin
                len = $urandom_range(1, 30);
            end
            for (int i = 0; i < len; i++) begin
                send_item(tbs_pkg::KIND_BYTE, pick_text_byte(), 1'b0, none);
            end
            send_item(tbs_pkg::KIND_EOT, 8'($urandom_range(0, 255)), 1'b0, none);
        end
        push <= 1'b0;

        while (exp_rd != exp_wr) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Hard limit well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/tbs_pkg.sv
hw/rtl/tbs_front.sv
hw/rtl/tbs_queue.sv
hw/rtl/tbs_back.sv
hw/rtl/text_byte_statistics.sv
bench/tb_text_byte_statistics.sv
